// ----- sv/sorted_order_book_table_top_macros.svh -----
// Assertion macros for the sorted order book table.
`ifndef SORTED_ORDER_BOOK_TABLE_TOP_MACROS_SVH
`define SORTED_ORDER_BOOK_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge out of reset.
`define SOBT_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("sobt assertion failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define SOBT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sobt assertion failed");
`else
`define SOBT_ASSERT(lbl, expr)
`define SOBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/sobt_pkg.sv -----
// Package with the types and constants of the sorted order book table.
`timescale 1ns / 1ps
`default_nettype none
package sobt_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PRICE_W = 32;
	localparam int QTY_W   = 32;
	localparam int VIS_RESET = 10;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_CHANGE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	// Operation that every cell applies in the cycle an item is accepted.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CHANGE = 2'd3
	} op_t;

	typedef struct packed {
		mode_t               mode;
		logic [PRICE_W-1:0]  price;
		logic [QTY_W-1:0]    quantity;
		logic                is_ask;
		logic [IDX_W-1:0]    read_index;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [CNT_W-1:0]    entry_count;
		logic [CNT_W-1:0]    ask_count;
		logic [CNT_W-1:0]    first_visible;
		logic [PRICE_W-1:0]  read_price;
		logic [QTY_W-1:0]    read_quantity;
		logic                read_is_ask;
	} res_t;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [QTY_W-1:0]    qty;
		logic                side;
	} row_t;

	typedef struct packed {
		op_t   op;
		row_t  nrow;
	} cell_cmd_t;

	// Per-cell control derived from the cell's position and its neighbors.
	typedef struct packed {
		logic  occ;      // row lies below the entry count
		logic  left_gt;  // left neighbor sorts ahead of the new price (or no left)
		logic  upto;     // a match exists at this row or before it
		logic  first;    // this row is the first match
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/sobt_cell.sv -----
// One row cell of the sorted order book chain.
`timescale 1ns / 1ps
`default_nettype none
module sobt_cell (
	input  wire logic               clk,
	input  wire sobt_pkg::cell_cmd_t cmd,
	input  wire sobt_pkg::cell_ctl_t ctl,
	input  wire sobt_pkg::row_t     left_row,
	input  wire sobt_pkg::row_t     right_row,
	output sobt_pkg::row_t          row,
	output logic                    gt,
	output logic                    match
);
	import sobt_pkg::*;

	row_t row_q;

	assign row   = row_q;
	assign gt    = ctl.occ && (row_q.price > cmd.nrow.price);
	assign match = ctl.occ && (row_q.price == cmd.nrow.price) && (row_q.side == cmd.nrow.side);

	// Rows shift right on insert and left on delete; the row data needs no reset.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (!gt) begin
					row_q <= ctl.left_gt ? cmd.nrow : left_row;
				end
			end
			OP_DELETE: begin
				if (ctl.upto) begin
					row_q <= right_row;
				end
			end
			OP_CHANGE: begin
				if (ctl.first) begin
					row_q.qty <= cmd.nrow.qty;
				end
			end
			default: begin
				row_q <= row_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/sorted_order_book_table_top.sv -----
// Top level of the price-sorted order book table built as a chain of row cells.
// A result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; every row cell compares
// and shifts in the same cycle, so the output register alone sets the pace.
// Reset clears the entry and ask counts, the result valid flag and sets vis_q
// to ten; row contents are not reset and are only ever read below the entry count.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_order_book_table_top_macros.svh"
module sorted_order_book_table_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_stall,
	input  wire sobt_pkg::cmd_t   cmd,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output sobt_pkg::res_t        res,
	input  wire logic             cfg_we,
	input  wire logic [sobt_pkg::CNT_W-1:0] cfg_data
);
	import sobt_pkg::*;

	// Control registers.
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] asks_q;
	logic [CNT_W-1:0] vis_q;
	logic             res_valid_q;
	res_t             res_q;

	// Chain signals, one element per row cell.
	row_t             rows   [DEPTH];
	logic [DEPTH-1:0] gt_vec;
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] first_vec;
	logic [DEPTH-1:0] sel_vec;
	cell_ctl_t        ctl    [DEPTH];
	cell_cmd_t        ccmd;

	logic             accept;
	logic             full;
	logic             found;
	logic             in_range;
	op_t              op;
	status_t          status;
	logic [CNT_W-1:0] held_n;
	logic [CNT_W-1:0] asks_n;
	logic [CNT_W-1:0] first_vis;
	row_t             read_row;

	// The result register holds one item; a new item enters whenever that
	// register is empty or is being drained in the same cycle.
	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign full     = (held_q == CNT_W'(DEPTH));
	assign found    = |match_vec;
	assign in_range = ({1'b0, cmd.read_index} < held_q);

	// Decode the mode into the operation the cells carry out and the status.
	always_comb begin
		op     = OP_HOLD;
		status = ST_OK;
		unique case (cmd.mode)
			MODE_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					op = OP_INSERT;
				end
			end
			MODE_DELETE: begin
				if (!found) begin
					status = ST_MISSING;
				end else begin
					op = OP_DELETE;
				end
			end
			MODE_CHANGE: begin
				if (!found) begin
					status = ST_MISSING;
				end else begin
					op = OP_CHANGE;
				end
			end
			MODE_READ: begin
				if (!in_range) begin
					status = ST_RANGE;
				end
			end
			default: begin
				op     = OP_HOLD;
				status = ST_OK;
			end
		endcase
	end

	assign ccmd.op         = accept ? op : OP_HOLD;
	assign ccmd.nrow.price = cmd.price;
	assign ccmd.nrow.qty   = cmd.quantity;
	assign ccmd.nrow.side  = cmd.is_ask;

	// The row chain. Each cell sees the new item, its left and right neighbors,
	// and whether a matching row sits at or before it.
	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		assign ctl[i].occ   = (CNT_W'(i) < held_q);
		assign ctl[i].upto  = |match_vec[i:0];
		assign sel_vec[i]   = (cmd.read_index == IDX_W'(i));
		if (i == 0) begin : g_first
			assign ctl[i].left_gt = 1'b1;
			assign ctl[i].first   = match_vec[i];
		end else begin : g_rest
			assign ctl[i].left_gt = gt_vec[i-1];
			assign ctl[i].first   = match_vec[i] && !(|match_vec[i-1:0]);
		end
		assign first_vec[i] = ctl[i].first;

		row_t lrow;
		row_t rrow;
		if (i == 0) begin : g_left_edge
			assign lrow = ccmd.nrow;
		end else begin : g_left
			assign lrow = rows[i-1];
		end
		if (i == DEPTH - 1) begin : g_right_edge
			assign rrow = rows[i];
		end else begin : g_right
			assign rrow = rows[i+1];
		end

		sobt_cell u_cell (
			.clk       (clk),
			.cmd       (ccmd),
			.ctl       (ctl[i]),
			.left_row  (lrow),
			.right_row (rrow),
			.row       (rows[i]),
			.gt        (gt_vec[i]),
			.match     (match_vec[i])
		);
	end

	// Row read: a one-hot select over the cells, merged by an AND-OR.
	always_comb begin
		read_row = '0;
		for (int j = 0; j < DEPTH; j++) begin
			read_row = read_row | (sel_vec[j] ? rows[j] : '0);
		end
	end

	// Counts after this item.
	always_comb begin
		held_n = held_q;
		asks_n = asks_q;
		case (op)
			OP_INSERT: begin
				held_n = held_q + CNT_W'(1);
				if (cmd.is_ask) begin
					asks_n = asks_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				held_n = held_q - CNT_W'(1);
				if (cmd.is_ask && (asks_q != '0)) begin
					asks_n = asks_q - CNT_W'(1);
				end
			end
			default: begin
				held_n = held_q;
				asks_n = asks_q;
			end
		endcase
		first_vis = (asks_n > vis_q) ? (asks_n - vis_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			asks_q      <= '0;
			vis_q       <= CNT_W'(VIS_RESET);
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vis_q <= cfg_data;
			end
			if (accept) begin
				held_q      <= held_n;
				asks_q      <= asks_n;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; it only loads when an item is accepted, so a stalled
	// result holds.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status        <= status;
			res_q.entry_count   <= held_n;
			res_q.ask_count     <= asks_n;
			res_q.first_visible <= first_vis;
			if ((cmd.mode == MODE_READ) && in_range) begin
				res_q.read_price    <= read_row.price;
				res_q.read_quantity <= read_row.qty;
				res_q.read_is_ask   <= read_row.side;
			end else begin
				res_q.read_price    <= '0;
				res_q.read_quantity <= '0;
				res_q.read_is_ask   <= 1'b0;
			end
		end
	end

	// The counts never run past the table size, and asks are a subset of entries.
	`SOBT_ASSERT(a_held_bound, held_q <= CNT_W'(DEPTH))
	`SOBT_ASSERT(a_asks_bound, asks_q <= held_q)
	// At most one row claims to be the first match.
	`SOBT_ASSERT(a_first_onehot, $onehot0(first_vec))
	// An accepted ask insert into a table with room raises the ask count by one.
	`SOBT_ASSERT_NEXT(a_ask_insert, accept && (op == OP_INSERT) && cmd.is_ask,
		asks_q == $past(asks_q) + CNT_W'(1))

endmodule
`default_nettype wire
